>>> hw/rtl/dfs_ts_pkg.sv
// Shared types and constants for the depth-first search time stamp block.
`timescale 1ns / 1ps
`default_nettype none

package dfs_ts_pkg;

  // Field widths of the item ports
  localparam int CMD_W        = 2;
  localparam int VERTEX_W     = 6;
  localparam int COUNT_W      = 7;
  localparam int STAMP_W      = 8;

  // Default graph size and vertex count after reset
  localparam int NUM_VERTICES_DEF = 32;
  localparam int VCOUNT_RESET     = 32;

  // Command codes of an input item
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  // Neighbor pick result handed from the pick unit to the sequencer
  typedef struct packed {
    logic                found;
    logic [VERTEX_W-1:0] vtx;
  } pick_t;

endpackage

`default_nettype wire

>>> hw/rtl/dfs_ts_pick.sv
// Neighbor pick unit: lowest unvisited in-use neighbor of the current row.
`timescale 1ns / 1ps
`default_nettype none

module dfs_ts_pick #(
  parameter int NUM_VERTICES = dfs_ts_pkg::NUM_VERTICES_DEF
) (
  input  logic [NUM_VERTICES-1:0] row_i,
  input  logic [NUM_VERTICES-1:0] visited_i,
  input  logic [NUM_VERTICES-1:0] in_use_i,
  output dfs_ts_pkg::pick_t       pick_o
);
  import dfs_ts_pkg::*;

  logic [NUM_VERTICES-1:0] cand;

  // Mask the row down to white vertices in use
  assign cand = row_i & in_use_i & ~visited_i;

  // Priority encode, lowest index wins
  always_comb begin
    pick_o.found = |cand;
    pick_o.vtx   = '0;
    for (int k = NUM_VERTICES - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick_o.vtx = VERTEX_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/depth_first_search_timestamps_top.sv
// Top level: graph store, depth-first walk sequencer and result emitter.
// Add edge: read-modify-write of both rows (ADD_RA/WA, ADD_RB/WB); clear graph on accept.
// Run: a discovery passes ROW and PICK, a finish PICK and POP, through the shared neighbor
// pick and one adjacency read port, then each result LOAD and EMIT once the output is free.
// A bad source gives its single result from state BAD once the output is free.
// Reset (async, active low) empties the graph, sets vertex_count to 32, idles the block.
`timescale 1ns / 1ps
`default_nettype none

module depth_first_search_timestamps_top #(
  parameter int NUM_VERTICES = dfs_ts_pkg::NUM_VERTICES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dfs_ts_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dfs_ts_pkg::CMD_W-1:0]     cmd_i,
  input  logic [dfs_ts_pkg::VERTEX_W-1:0]  vertex_a_i,
  input  logic [dfs_ts_pkg::VERTEX_W-1:0]  vertex_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dfs_ts_pkg::VERTEX_W-1:0]  vertex_o,
  output logic [dfs_ts_pkg::VERTEX_W-1:0]  parent_vertex_o,
  output logic                             is_root_o,
  output logic [dfs_ts_pkg::STAMP_W-1:0]   discovery_stamp_o,
  output logic [dfs_ts_pkg::STAMP_W-1:0]   finishing_stamp_o,
  output logic                             is_last_o,
  output logic                             bad_source_o
);
  import dfs_ts_pkg::*;

  localparam int VW   = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int CNTW = $clog2(NUM_VERTICES + 1);
  localparam int SW   = $clog2(2 * NUM_VERTICES + 1);
  localparam int RECW = 2 * VW + SW;
  localparam int STKW = 2 * VW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RA,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_BAD,
    S_ROW,
    S_PICK,
    S_POP,
    S_LOAD,
    S_EMIT
  } state_e;

  state_e state_q;

  // Configuration and graph state
  logic [COUNT_W-1:0]      vcount_q;
  logic [COUNT_W-1:0]      n_eff;
  logic [NUM_VERTICES-1:0] in_use;
  logic [NUM_VERTICES-1:0] row_valid_q;
  logic [NUM_VERTICES-1:0] visited_q;

  // Adjacency memory and its read port
  logic [NUM_VERTICES-1:0] adj_mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] adj_rd_q;
  logic                    adj_rv_q;
  logic [NUM_VERTICES-1:0] adj_row;
  logic [VW-1:0]           adj_raddr;
  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [NUM_VERTICES-1:0] adj_wdata;

  // Edge endpoints of an add command
  logic [VW-1:0] ea_q;
  logic [VW-1:0] eb_q;

  // Walk state: top of stack in registers, the rest in memory
  logic [VW-1:0]   top_u_q;
  logic [VW-1:0]   top_idx_q;
  logic [VW-1:0]   below_q;
  logic [STKW-1:0] stk_mem [NUM_VERTICES];
  logic [STKW-1:0] stk_rd_q;
  logic            stk_we;
  logic [VW-1:0]   stk_raddr;
  logic [CNTW-1:0] seen_q;
  logic [SW-1:0]   stamp_q;
  logic [SW-1:0]   stamp_nx;
  logic [VW-1:0]   k_q;

  // Result records indexed by discovery order
  logic [RECW-1:0] rec_mem [NUM_VERTICES];
  logic [RECW-1:0] rec_rd_q;
  logic            rec_we;
  logic [VW-1:0]   rec_waddr;
  logic [RECW-1:0] rec_wdata;
  logic [SW-1:0]   fin_mem [NUM_VERTICES];
  logic [SW-1:0]   fin_rd_q;
  logic            fin_we;

  // Input decode
  cmd_e            cmd;
  logic            in_acc;
  logic            edge_ok;
  logic            src_bad;
  logic [VW-1:0]   a_idx;
  logic [VW-1:0]   b_idx;
  pick_t           pick;
  logic [VW-1:0]   pick_v;
  logic            out_free;
  logic            out_load;
  logic            rec_last;
  logic            rec_root;

  assign cmd      = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc   = in_valid_i & in_ready_o;
  assign a_idx    = vertex_a_i[VW-1:0];
  assign b_idx    = vertex_b_i[VW-1:0];
  assign edge_ok  = (COUNT_W'(vertex_a_i) < COUNT_W'(NUM_VERTICES)) &&
                    (COUNT_W'(vertex_b_i) < COUNT_W'(NUM_VERTICES));
  assign n_eff    = (vcount_q > COUNT_W'(NUM_VERTICES)) ? COUNT_W'(NUM_VERTICES) : vcount_q;
  assign src_bad  = COUNT_W'(vertex_a_i) >= n_eff;
  assign stamp_nx = stamp_q + SW'(1);
  assign out_free = !out_valid_o || out_ready_i;
  assign out_load = out_free && ((state_q == S_BAD) || (state_q == S_EMIT));
  assign adj_row  = adj_rv_q ? adj_rd_q : '0;
  assign pick_v   = pick.vtx[VW-1:0];
  assign rec_last = (CNTW'(k_q) + CNTW'(1)) == seen_q;
  assign rec_root = (k_q == '0);

  // Mark vertices below the active count
  always_comb begin
    for (int k = 0; k < NUM_VERTICES; k++) begin
      in_use[k] = COUNT_W'(k) < n_eff;
    end
  end

  dfs_ts_pick #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_pick (
    .row_i     (adj_row),
    .visited_i (visited_q),
    .in_use_i  (in_use),
    .pick_o    (pick)
  );

  // Adjacency port control: row reads follow the sequencer
  always_comb begin
    unique case (state_q)
      S_ADD_RA: adj_raddr = ea_q;
      S_ADD_RB: adj_raddr = eb_q;
      default:  adj_raddr = top_u_q;
    endcase
    adj_we    = (state_q == S_ADD_WA) || (state_q == S_ADD_WB);
    adj_waddr = (state_q == S_ADD_WA) ? ea_q : eb_q;
    adj_wdata = adj_row | (NUM_VERTICES'(1) << ((state_q == S_ADD_WA) ? eb_q : ea_q));
  end

  // Record and stack write control
  always_comb begin
    stk_we    = (state_q == S_PICK) && pick.found;
    stk_raddr = below_q - VW'(1);
    fin_we    = (state_q == S_PICK) && !pick.found;
    rec_we    = 1'b0;
    rec_waddr = seen_q[VW-1:0];
    rec_wdata = {pick_v, top_u_q, stamp_nx};
    if (in_acc && (cmd == CMD_RUN) && !src_bad) begin
      rec_we    = 1'b1;
      rec_waddr = '0;
      rec_wdata = {a_idx, VW'(0), SW'(1)};
    end else if (stk_we) begin
      rec_we = 1'b1;
    end
  end

  // Adjacency memory
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd_q <= adj_mem[adj_raddr];
    adj_rv_q <= row_valid_q[adj_raddr];
  end

  // Stack memory below the top entry
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[below_q] <= {top_u_q, top_idx_q};
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  // Record and finish stamp memories
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (fin_we) begin
      fin_mem[top_idx_q] <= stamp_nx;
    end
    rec_rd_q <= rec_mem[k_q];
    fin_rd_q <= fin_mem[k_q];
  end

  // Sequencer with registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      vcount_q          <= COUNT_W'(VCOUNT_RESET);
      row_valid_q       <= '0;
      visited_q         <= '0;
      ea_q              <= '0;
      eb_q              <= '0;
      top_u_q           <= '0;
      top_idx_q         <= '0;
      below_q           <= '0;
      seen_q            <= '0;
      stamp_q           <= '0;
      k_q               <= '0;
      out_valid_o       <= 1'b0;
      vertex_o          <= '0;
      parent_vertex_o   <= '0;
      is_root_o         <= 1'b0;
      discovery_stamp_o <= '0;
      finishing_stamp_o <= '0;
      is_last_o         <= 1'b0;
      bad_source_o      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      // Drop the result once taken unless a new one loads
      if (out_valid_o && out_ready_i && !out_load) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              CMD_ADD_EDGE: begin
                if (edge_ok) begin
                  ea_q    <= a_idx;
                  eb_q    <= b_idx;
                  state_q <= S_ADD_RA;
                end
              end
              CMD_CLEAR: begin
                row_valid_q <= '0;
              end
              CMD_RUN: begin
                if (src_bad) begin
                  state_q <= S_BAD;
                end else begin
                  visited_q <= NUM_VERTICES'(1) << a_idx;
                  stamp_q   <= SW'(1);
                  seen_q    <= CNTW'(1);
                  top_u_q   <= a_idx;
                  top_idx_q <= '0;
                  below_q   <= '0;
                  state_q   <= S_ROW;
                end
              end
              CMD_NOP: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RA: state_q <= S_ADD_WA;
        S_ADD_WA: begin
          row_valid_q[ea_q] <= 1'b1;
          state_q           <= S_ADD_RB;
        end
        S_ADD_RB: state_q <= S_ADD_WB;
        S_ADD_WB: begin
          row_valid_q[eb_q] <= 1'b1;
          state_q           <= S_IDLE;
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_o       <= 1'b1;
            vertex_o          <= '0;
            parent_vertex_o   <= '0;
            is_root_o         <= 1'b0;
            discovery_stamp_o <= '0;
            finishing_stamp_o <= '0;
            is_last_o         <= 1'b1;
            bad_source_o      <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        S_ROW: state_q <= S_PICK;
        S_PICK: begin
          stamp_q <= stamp_nx;
          if (pick.found) begin
            // Discover: push the current top, enter the neighbor
            visited_q[pick_v] <= 1'b1;
            seen_q            <= seen_q + CNTW'(1);
            top_u_q           <= pick_v;
            top_idx_q         <= seen_q[VW-1:0];
            below_q           <= below_q + VW'(1);
            state_q           <= S_ROW;
          end else if (below_q == '0) begin
            // Source finished: walk is over
            k_q     <= '0;
            state_q <= S_LOAD;
          end else begin
            below_q <= below_q - VW'(1);
            state_q <= S_POP;
          end
        end
        S_POP: begin
          top_u_q   <= stk_rd_q[STKW-1 -: VW];
          top_idx_q <= stk_rd_q[VW-1:0];
          state_q   <= S_ROW;
        end
        S_LOAD: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid_o       <= 1'b1;
            vertex_o          <= VERTEX_W'(rec_rd_q[RECW-1 -: VW]);
            parent_vertex_o   <= rec_root ? '0 : VERTEX_W'(rec_rd_q[SW+VW-1 -: VW]);
            is_root_o         <= rec_root;
            discovery_stamp_o <= STAMP_W'(rec_rd_q[SW-1:0]);
            finishing_stamp_o <= STAMP_W'(fin_rd_q);
            is_last_o         <= rec_last;
            bad_source_o      <= 1'b0;
            if (rec_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + VW'(1);
              state_q <= S_LOAD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Walk invariants
  logic walking;
  assign walking = (state_q == S_ROW) || (state_q == S_PICK) || (state_q == S_POP);

  a_seen_matches_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking |-> ($countones(visited_q) == int'(seen_q)))
    else $error("visited set and discovery count disagree");

  a_stack_within_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking |-> (CNTW'(below_q) < seen_q))
    else $error("stack deeper than discovered vertices");

  a_top_is_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking |-> visited_q[top_u_q])
    else $error("top of stack not a discovered vertex");

  a_stamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking |-> (int'(stamp_q) < 2 * int'(seen_q)))
    else $error("time stamp beyond two per discovered vertex");

endmodule

`default_nettype wire

>>> bench/depth_first_search_timestamps_top_test.sv
// Self-checking testbench for the depth-first search time stamp block.
`timescale 1ns / 1ps

module depth_first_search_timestamps_top_test;
  import dfs_ts_pkg::*;

  localparam int NV          = NUM_VERTICES_DEF;
  localparam int LONG_HOLD   = 400;   // receiver hold-off that fills the block
  localparam int SETTLE      = 12;    // cycles after the last result before a register write
  localparam int STALL_LIMIT = 5000;  // cycles with no item moving on either side

  // One visit reported by the block
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] parent_vertex;
    logic                is_root;
    logic [STAMP_W-1:0]  discovery_stamp;
    logic [STAMP_W-1:0]  finishing_stamp;
    logic                is_last;
    logic                bad_source;
  } dfs_visit_t;

  typedef enum logic [1:0] {SHADE_WHITE, SHADE_GRAY, SHADE_BLACK} shade_e;

  // Graph mirror, walk predictor and queue of visits still to come
  class dfs_stamp_board;
    logic [NV-1:0] adj_row [NV];
    int unsigned   vcount;
    dfs_visit_t    visits_due[$];
    int            mismatches;
    int            visits_checked;
    int            searches;

    function new();
      foreach (adj_row[i]) adj_row[i] = '0;
      vcount         = VCOUNT_RESET;
      mismatches     = 0;
      visits_checked = 0;
      searches       = 0;
    endfunction

    function int eff_count();
      return (vcount > NV) ? NV : vcount;
    endfunction

    function void set_count(int unsigned v);
      vcount = v;
    endfunction

    function int pending();
      return visits_due.size();
    endfunction

    function string fmt_visit(dfs_visit_t r);
      return $sformatf("vertex=%0d parent=%0d root=%0b disc=%0d fin=%0d last=%0b bad=%0b",
                       r.vertex, r.parent_vertex, r.is_root, r.discovery_stamp,
                       r.finishing_stamp, r.is_last, r.bad_source);
    endfunction

    // Apply one accepted item to the mirror
    function void note_item(cmd_e c, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
      case (c)
        CMD_ADD_EDGE: begin
          if (a < NV && b < NV) begin
            adj_row[a][b] = 1'b1;
            adj_row[b][a] = 1'b1;
          end
        end
        CMD_CLEAR: begin
          foreach (adj_row[i]) adj_row[i] = '0;
        end
        CMD_RUN: begin
          searches++;
          predict_walk(a);
        end
        default: ;
      endcase
    endfunction

    // Walk from src with an explicit stack, lowest neighbor first
    function void predict_walk(logic [VERTEX_W-1:0] src);
      shade_e     shade [NV];
      int         parent [NV];
      int         disc [NV];
      int         fin [NV];
      int         order[$];
      int         stack[$];
      int         stamp;
      int         n;
      int         u;
      int         nb;
      dfs_visit_t r;
      n = eff_count();
      r = '0;
      if (src >= n) begin
        r.is_last    = 1'b1;
        r.bad_source = 1'b1;
        visits_due.push_back(r);
        return;
      end
      foreach (shade[k]) shade[k] = SHADE_WHITE;
      stamp = 1;
      shade[src]  = SHADE_GRAY;
      parent[src] = 0;
      disc[src]   = stamp;
      order.push_back(int'(src));
      stack.push_back(int'(src));
      while (stack.size() > 0) begin
        u  = stack[stack.size()-1];
        nb = -1;
        for (int k = 0; k < n; k++)
          if (nb < 0 && shade[k] == SHADE_WHITE && adj_row[u][k]) nb = k;
        stamp++;
        if (nb >= 0) begin
          // descend into the lowest white neighbor
          shade[nb]  = SHADE_GRAY;
          parent[nb] = u;
          disc[nb]   = stamp;
          order.push_back(nb);
          stack.push_back(nb);
        end else begin
          // no white neighbor left: finish and pop
          void'(stack.pop_back());
          shade[u] = SHADE_BLACK;
          fin[u]   = stamp;
        end
      end
      foreach (order[i]) begin
        r.vertex          = VERTEX_W'(order[i]);
        r.is_root         = (order[i] == src);
        r.parent_vertex   = r.is_root ? '0 : VERTEX_W'(parent[order[i]]);
        r.discovery_stamp = STAMP_W'(disc[order[i]]);
        r.finishing_stamp = STAMP_W'(fin[order[i]]);
        r.is_last         = (i == order.size() - 1);
        r.bad_source      = 1'b0;
        visits_due.push_back(r);
      end
    endfunction

    // Compare one accepted result with the oldest visit due
    function void check_visit(dfs_visit_t got);
      dfs_visit_t want;
      if (visits_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: expected none, actual %s",
                 $time, fmt_visit(got));
        return;
      end
      want = visits_due.pop_front();
      visits_checked++;
      if (got.vertex !== want.vertex || got.parent_vertex !== want.parent_vertex ||
          got.is_root !== want.is_root || got.discovery_stamp !== want.discovery_stamp ||
          got.finishing_stamp !== want.finishing_stamp || got.is_last !== want.is_last ||
          got.bad_source !== want.bad_source) begin
        mismatches++;
        $display("%0t: result mismatch: expected %s", $time, fmt_visit(want));
        $display("%0t:                  actual   %s", $time, fmt_visit(got));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i = '0;
  logic [VERTEX_W-1:0] vertex_a_i = '0;
  logic [VERTEX_W-1:0] vertex_b_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [VERTEX_W-1:0] vertex_o;
  logic [VERTEX_W-1:0] parent_vertex_o;
  logic                is_root_o;
  logic [STAMP_W-1:0]  discovery_stamp_o;
  logic [STAMP_W-1:0]  finishing_stamp_o;
  logic                is_last_o;
  logic                bad_source_o;

  dfs_stamp_board board = new();
  int  sender_idle_pct = 0;
  int  sink_idle_pct = 0;
  bit  sink_hold_req = 1'b0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  settings_used = 1;

  depth_first_search_timestamps_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .vertex_o          (vertex_o),
    .parent_vertex_o   (parent_vertex_o),
    .is_root_o         (is_root_o),
    .discovery_stamp_o (discovery_stamp_o),
    .finishing_stamp_o (finishing_stamp_o),
    .is_last_o         (is_last_o),
    .bad_source_o      (bad_source_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_visit({vertex_o, parent_vertex_o, is_root_o, discovery_stamp_o,
                         finishing_stamp_o, is_last_o, bad_source_o});
  end

  // End the run when no item moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive result ready: long hold on request, else random stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (sink_hold_req) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Offer one item and hold it until accepted; returns at a falling edge
  task automatic send_cmd(cmd_e c, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = c;
    vertex_a_i = a;
    vertex_b_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(c, a, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and let every expected result drain, then the block go idle
  task automatic drain_block();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Write vertex_count while the block is idle
  task automatic write_count(int unsigned v);
    drain_block();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = COUNT_W'(v);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    board.set_count(v);
    settings_used++;
  endtask

  // Random items, mostly edges and searches inside the active vertex range
  task automatic random_items(int count);
    int n;
    int span;
    int pick;
    for (int i = 0; i < count; i++) begin
      n    = board.eff_count();
      span = (n == 0) ? 4 : ((n + 2 > NV) ? NV : n + 2);
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_cmd(CMD_ADD_EDGE, VERTEX_W'($urandom_range(0, span - 1)),
                 VERTEX_W'($urandom_range(0, span - 1)));
      else if (pick < 62)
        send_cmd(CMD_ADD_EDGE, VERTEX_W'($urandom_range(0, 63)),
                 VERTEX_W'($urandom_range(0, 63)));
      else if (pick < 87)
        send_cmd(CMD_RUN, VERTEX_W'($urandom_range(0, (n == 0) ? 0 : n - 1)),
                 VERTEX_W'($urandom_range(0, 63)));
      else if (pick < 91)
        send_cmd(CMD_RUN, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
      else if (pick < 94)
        send_cmd(CMD_CLEAR, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
      else
        send_cmd(CMD_NOP, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
    end
  endtask

  // Pick idle rates for a phase, sometimes none at all
  task automatic pick_idling();
    sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
    sink_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
  endtask

  initial begin
    int unsigned counts [7];
    counts = '{0, 1, 2, 127, 7, 20, 31};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty graph, self loop, ignored endpoints, bad sources, clear
    send_cmd(CMD_RUN,      6'd0,  6'd63);
    send_cmd(CMD_ADD_EDGE, 6'd0,  6'd1);
    send_cmd(CMD_ADD_EDGE, 6'd1,  6'd2);
    send_cmd(CMD_ADD_EDGE, 6'd0,  6'd31);
    send_cmd(CMD_ADD_EDGE, 6'd31, 6'd31);
    send_cmd(CMD_ADD_EDGE, 6'd2,  6'd63);
    send_cmd(CMD_ADD_EDGE, 6'd63, 6'd0);
    send_cmd(CMD_ADD_EDGE, 6'd40, 6'd5);
    send_cmd(CMD_ADD_EDGE, 6'd5,  6'd6);
    send_cmd(CMD_ADD_EDGE, 6'd6,  6'd2);
    send_cmd(CMD_NOP,      6'd63, 6'd63);
    send_cmd(CMD_RUN,      6'd0,  6'd0);
    send_cmd(CMD_RUN,      6'd31, 6'd42);
    send_cmd(CMD_RUN,      6'd63, 6'd0);
    send_cmd(CMD_RUN,      6'd32, 6'd21);
    send_cmd(CMD_RUN,      6'd5,  6'd63);
    send_cmd(CMD_CLEAR,    6'd63, 6'd63);
    send_cmd(CMD_RUN,      6'd1,  6'd0);
    send_cmd(CMD_ADD_EDGE, 6'd30, 6'd31);
    send_cmd(CMD_RUN,      6'd31, 6'd0);

    // Zero count: every search is a bad source
    write_count(0);
    send_cmd(CMD_RUN, 6'd0, 6'd0);
    // One vertex: only the root, self loop not followed, vertex 1 a bad source
    write_count(1);
    send_cmd(CMD_ADD_EDGE, 6'd0, 6'd0);
    send_cmd(CMD_RUN,      6'd0, 6'd0);
    send_cmd(CMD_RUN,      6'd1, 6'd0);

    // Random phases across the count settings, extremes first
    foreach (counts[i]) begin
      write_count(counts[i]);
      pick_idling();
      random_items((counts[i] == 0) ? 15 : 52);
    end

    // Fill the block: long chain, many searches while the receiver holds off
    write_count(64);
    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    send_cmd(CMD_CLEAR, 6'd0, 6'd0);
    for (int v = 0; v < 20; v++) send_cmd(CMD_ADD_EDGE, VERTEX_W'(v), VERTEX_W'(v + 1));
    sink_hold_req = 1'b1;
    repeat (8) send_cmd(CMD_RUN, VERTEX_W'($urandom_range(0, 20)),
                        VERTEX_W'($urandom_range(0, 63)));

    // Last part: back to the reset count, no idling on either side
    write_count(VCOUNT_RESET);
    random_items(80);

    drain_block();
    $display("Sent %0d items with %0d searches over %0d vertex_count settings.",
             items_sent, board.searches, settings_used);
    $display("Checked %0d results, %0d mismatches.", board.visits_checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
